// ===== src/ppct_pkg.sv =====
package ppct_pkg;

   localparam int WORD_W = 32;
   localparam int NDC_W  = 18;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_POINT = 1'b1;

endpackage

// ===== src/point_project_clip_test_unit.sv =====
// Projects a point (x, y, z, 1) through a 4x4 signed fixed-point matrix held in a
// 16-word memory, then tests it against the clip volume. A write word (opcode 0)
// stores one matrix entry and gives no response. A point word (opcode 1) gives
// one response. The path is serial. Twelve products and four bias terms stream
// through one 33x33 multiplier behind the registered memory read. A restoring
// divider then forms 2^(2*FRAC_BITS)/w at one quotient bit per cycle. The same
// multiplier scales x, y and z, each through the MUL_HI, MUL_LO and QUOT states.
// A point path is shorter when w is zero, w is huge or a coordinate falls
// outside. The response register frees the input side as soon as the response
// has been loaded.
module point_project_clip_test_unit
   import ppct_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [3:0]               req_entry_index,
   input  logic signed [WORD_W-1:0] req_entry_value,
   input  logic signed [WORD_W-1:0] req_point_x,
   input  logic signed [WORD_W-1:0] req_point_y,
   input  logic signed [WORD_W-1:0] req_point_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_outside,
   output logic signed [NDC_W-1:0]  rsp_ndc_x,
   output logic signed [NDC_W-1:0]  rsp_ndc_y,
   output logic signed [NDC_W-1:0]  rsp_ndc_z,
   output logic signed [WORD_W-1:0] rsp_recip_w
);

   localparam int ACC_W = 66 - FRAC_BITS;        // clip accumulator
   localparam int DW    = 2 * FRAC_BITS + 1;     // divisor / quotient width
   localparam int CNT_W = $clog2(DW);

   typedef enum logic [3:0] {
      S_IDLE, S_CLIP, S_RECIP, S_DIV, S_SAT, S_MUL_HI, S_MUL_LO, S_QUOT, S_DONE
   } state_type;

   state_type state_ff;

   logic [WORD_W-1:0]        mem [16];
   logic [15:0]              vld_ff;
   logic [WORD_W-1:0]        rd_ff;
   logic                     rd_ok_ff;

   logic signed [WORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [4:0]               iss_ff;
   logic                     s1_vld_ff, s2_vld_ff;
   logic [3:0]               s1_k_ff, s2_k_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  clip_ff [4];

   logic signed [32:0]       mul_a, mul_b;
   logic signed [65:0]       prod_ff;

   logic                     rneg_ff;
   logic [DW-1:0]            div_ff;
   logic [DW:0]              rem_ff;
   logic [DW-1:0]            q_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [WORD_W-1:0]        rmag_ff;
   logic [1:0]               idx_ff;
   logic [63:0]              hi_ff;

   logic                     out_outside_ff;
   logic signed [NDC_W-1:0]  ndc_x_ff, ndc_y_ff, ndc_z_ff;

   logic                     rsp_valid_ff, rsp_outside_ff;
   logic signed [NDC_W-1:0]  rsp_ndc_x_ff, rsp_ndc_y_ff, rsp_ndc_z_ff;
   logic signed [WORD_W-1:0] rsp_recip_ff;

   // combinational helpers
   logic [3:0]               rd_addr;
   logic [WORD_W-1:0]        rd_val;
   logic signed [65:0]       prod_sh;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  w_val, c_val;
   logic [ACC_W-1:0]         wmag, cmag;
   logic                     cneg;
   logic [DW:0]              rem_sh;
   logic [63:0]              qv, q_in;
   logic signed [63:0]       ndc_in;
   logic                     take;

   assign req_ready   = (state_ff == S_IDLE);
   assign take        = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outside = rsp_outside_ff;
   assign rsp_ndc_x   = rsp_ndc_x_ff;
   assign rsp_ndc_y   = rsp_ndc_y_ff;
   assign rsp_ndc_z   = rsp_ndc_z_ff;
   assign rsp_recip_w = rsp_recip_ff;

   // term k = col*4 + row lives at row*4 + col
   assign rd_addr = {iss_ff[1:0], iss_ff[3:2]};
   assign rd_val  = rd_ok_ff ? rd_ff : '0;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_CLIP) begin
         mul_a = {rd_val[WORD_W-1], rd_val};
         case (s1_k_ff[1:0])
            2'd0:    mul_b = {px_ff[WORD_W-1], px_ff};
            2'd1:    mul_b = {py_ff[WORD_W-1], py_ff};
            2'd2:    mul_b = {pz_ff[WORD_W-1], pz_ff};
            default: mul_b = 33'(64'd1 << FRAC_BITS);  // bias row
         endcase
      end else if (state_ff == S_MUL_HI) begin
         mul_a = {1'b0, 32'(cmag >> 32)};
         mul_b = {1'b0, rmag_ff};
      end else if (state_ff == S_MUL_LO) begin
         mul_a = {1'b0, cmag[31:0]};
         mul_b = {1'b0, rmag_ff};
      end
   end

   always_comb begin
      prod_sh = prod_ff >>> FRAC_BITS;
      acc_in  = ((s2_k_ff[1:0] == 2'd0) ? '0 : acc_ff) + prod_sh[ACC_W-1:0];
      w_val   = clip_ff[3];
      wmag    = w_val[ACC_W-1] ? ACC_W'(-w_val) : ACC_W'(w_val);
      c_val   = clip_ff[idx_ff];
      cneg    = c_val[ACC_W-1];
      cmag    = cneg ? ACC_W'(-c_val) : ACC_W'(c_val);
      rem_sh  = {rem_ff[DW-1:0], (cnt_ff == CNT_W'(DW - 1))};
      qv      = 64'(q_ff);
      q_in    = (hi_ff << (32 - FRAC_BITS)) + (64'(prod_ff[63:0]) >> FRAC_BITS);
      ndc_in  = (cneg != rneg_ff) ? -$signed(q_in) : $signed(q_in);
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      rd_ff   <= mem[rd_addr];
      if (take && req_opcode == OP_WRITE) begin
         mem[req_entry_index] <= req_entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         vld_ff         <= '0;
         rd_ok_ff       <= 1'b0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         iss_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rd_ok_ff  <= vld_ff[rd_addr];
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= s1_vld_ff;
         s2_k_ff   <= s1_k_ff;
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  if (req_opcode == OP_WRITE) begin
                     vld_ff[req_entry_index] <= 1'b1;
                  end else begin
                     px_ff    <= req_point_x;
                     py_ff    <= req_point_y;
                     pz_ff    <= req_point_z;
                     iss_ff   <= '0;
                     state_ff <= S_CLIP;
                  end
               end
            end
            S_CLIP: begin
               if (!iss_ff[4]) begin
                  s1_vld_ff <= 1'b1;
                  s1_k_ff   <= iss_ff[3:0];
                  iss_ff    <= iss_ff + 5'd1;
               end
               if (s2_vld_ff) begin
                  acc_ff <= acc_in;
                  if (s2_k_ff[1:0] == 2'd3) begin
                     clip_ff[s2_k_ff[3:2]] <= acc_in;
                  end
                  if (s2_k_ff == 4'd15) begin
                     state_ff <= S_RECIP;
                  end
               end
            end
            S_RECIP: begin
               rneg_ff  <= w_val[ACC_W-1];
               ndc_x_ff <= '0;
               ndc_y_ff <= '0;
               ndc_z_ff <= '0;
               rmag_ff  <= '0;
               if (wmag == '0) begin
                  out_outside_ff <= 1'b1;
                  state_ff       <= S_DONE;
               end else if (64'(wmag) > (64'd1 << (2 * FRAC_BITS))) begin
                  q_ff     <= '0;
                  state_ff <= S_SAT;
               end else begin
                  div_ff   <= wmag[DW-1:0];
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= CNT_W'(DW - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // one quotient bit per cycle of 2^(2F) / |w|
               if (rem_sh >= {1'b0, div_ff}) begin
                  rem_ff <= rem_sh - {1'b0, div_ff};
                  q_ff   <= {q_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  q_ff   <= {q_ff[DW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               if (rneg_ff) begin
                  rmag_ff <= (qv > 64'h8000_0000) ? 32'h8000_0000 : qv[31:0];
               end else begin
                  rmag_ff <= (qv > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv[31:0];
               end
               idx_ff   <= 2'd0;
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               state_ff <= S_MUL_LO;
            end
            S_MUL_LO: begin
               hi_ff <= prod_ff[63:0];
               if (prod_ff[63:0] > (64'd1 << (FRAC_BITS + 1))) begin
                  out_outside_ff <= 1'b1;
                  state_ff       <= S_DONE;
               end else begin
                  state_ff <= S_QUOT;
               end
            end
            S_QUOT: begin
               if (q_in > (64'd1 << FRAC_BITS)) begin
                  out_outside_ff <= 1'b1;
                  state_ff       <= S_DONE;
               end else begin
                  case (idx_ff)
                     2'd0:    ndc_x_ff <= ndc_in[NDC_W-1:0];
                     2'd1:    ndc_y_ff <= ndc_in[NDC_W-1:0];
                     default: ndc_z_ff <= ndc_in[NDC_W-1:0];
                  endcase
                  if (idx_ff == 2'd2) begin
                     out_outside_ff <= 1'b0;
                     state_ff       <= S_DONE;
                  end else begin
                     idx_ff   <= idx_ff + 2'd1;
                     state_ff <= S_MUL_HI;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_outside_ff <= out_outside_ff;
                  rsp_ndc_x_ff   <= out_outside_ff ? '0 : ndc_x_ff;
                  rsp_ndc_y_ff   <= out_outside_ff ? '0 : ndc_y_ff;
                  rsp_ndc_z_ff   <= out_outside_ff ? '0 : ndc_z_ff;
                  rsp_recip_ff   <= out_outside_ff ? '0 :
                                    (rneg_ff ? -$signed(rmag_ff) : $signed(rmag_ff));
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== dv/point_project_clip_test_unit_tb.sv =====
`timescale 1ns / 100ps

module point_project_clip_test_unit_tb
   import ppct_pkg::*;
();

   localparam int FRAC = 16;

   typedef struct packed {
      logic                    outside;
      logic signed [NDC_W-1:0] ndc_x;
      logic signed [NDC_W-1:0] ndc_y;
      logic signed [NDC_W-1:0] ndc_z;
      logic signed [WORD_W-1:0] recip_w;
   } projection_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_opcode;
   logic [3:0]               req_entry_index;
   logic signed [WORD_W-1:0] req_entry_value;
   logic signed [WORD_W-1:0] req_point_x;
   logic signed [WORD_W-1:0] req_point_y;
   logic signed [WORD_W-1:0] req_point_z;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_outside;
   logic signed [NDC_W-1:0]  rsp_ndc_x;
   logic signed [NDC_W-1:0]  rsp_ndc_y;
   logic signed [NDC_W-1:0]  rsp_ndc_z;
   logic signed [WORD_W-1:0] rsp_recip_w;

   logic signed [WORD_W-1:0] matrix_copy [16];
   projection_type           pending_projections [$];
   int                       error_count;
   int                       burst_left;

   point_project_clip_test_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("point_project_clip_test_unit_tb: done, errors");
      $finish;
   end

   function automatic longint floor_div_frac(longint v);
      return v >>> FRAC;   // arithmetic shift is floor
   endfunction

   function automatic projection_type project_point(logic signed [WORD_W-1:0] px,
                                                    logic signed [WORD_W-1:0] py,
                                                    logic signed [WORD_W-1:0] pz);
      projection_type res;
      longint      clip [4];
      longint      p [3];
      longint unsigned wmag, qr, cmag, q, hi;
      bit          wneg, cneg, over;
      longint      recip;
      longint      ndc [3];
      res = '0;
      p[0] = px; p[1] = py; p[2] = pz;
      over = 1'b0;
      for (int c = 0; c < 4; c++) begin
         clip[c] = matrix_copy[12 + c];
         for (int r = 0; r < 3; r++)
            clip[c] += floor_div_frac(longint'(matrix_copy[r*4 + c]) * p[r]);
      end
      if (clip[3] == 0) begin
         res.outside = 1'b1;
         return res;
      end
      wneg = clip[3] < 0;
      wmag = wneg ? -clip[3] : clip[3];
      qr = (64'd1 << (2*FRAC)) / wmag;
      if (wneg) begin
         if (qr > 64'h8000_0000) qr = 64'h8000_0000;
         recip = -longint'(qr);
      end else begin
         if (qr > 64'h7FFF_FFFF) qr = 64'h7FFF_FFFF;
         recip = qr;
      end
      for (int i = 0; i < 3; i++) begin
         cneg = clip[i] < 0;
         cmag = cneg ? -clip[i] : clip[i];
         hi = (cmag >> 32) * qr;
         if (hi > (64'd1 << (FRAC + 1))) begin
            over = 1'b1;
            break;
         end
         q = (hi << (32 - FRAC)) + (((cmag & 64'hFFFF_FFFF) * qr) >> FRAC);
         if (q > (64'd1 << FRAC)) begin
            over = 1'b1;
            break;
         end
         ndc[i] = (cneg != wneg) ? -longint'(q) : longint'(q);
      end
      if (over) begin
         res.outside = 1'b1;
         return res;
      end
      res.ndc_x   = ndc[0][NDC_W-1:0];
      res.ndc_y   = ndc[1][NDC_W-1:0];
      res.ndc_z   = ndc[2][NDC_W-1:0];
      res.recip_w = recip[WORD_W-1:0];
      return res;
   endfunction

   // receiver stall pattern: alternating free runs and stall runs
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 60)) @(posedge clock);
         if ($urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      projection_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_outside, rsp_ndc_x, rsp_ndc_y, rsp_ndc_z, rsp_recip_w};
         if (pending_projections.size() == 0) begin
            $error("unexpected result word");
            error_count++;
         end else begin
            want = pending_projections.pop_front();
            if (got.outside !== want.outside) begin
               $error("outside: expected %0d, got %0d", want.outside, got.outside);
               error_count++;
            end
            if (got.ndc_x !== want.ndc_x) begin
               $error("ndc_x: expected %0d, got %0d", want.ndc_x, got.ndc_x);
               error_count++;
            end
            if (got.ndc_y !== want.ndc_y) begin
               $error("ndc_y: expected %0d, got %0d", want.ndc_y, got.ndc_y);
               error_count++;
            end
            if (got.ndc_z !== want.ndc_z) begin
               $error("ndc_z: expected %0d, got %0d", want.ndc_z, got.ndc_z);
               error_count++;
            end
            if (got.recip_w !== want.recip_w) begin
               $error("recip_w: expected %0d, got %0d", want.recip_w, got.recip_w);
               error_count++;
            end
         end
      end
   end

   // one word; bursts with random gaps before the word
   task automatic send_word(logic op, logic [3:0] idx, logic signed [WORD_W-1:0] val,
                            logic signed [WORD_W-1:0] px, logic signed [WORD_W-1:0] py,
                            logic signed [WORD_W-1:0] pz);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_point_x     <= px;
      req_point_y     <= py;
      req_point_z     <= pz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_WRITE)
         matrix_copy[idx] = val;
      else
         pending_projections.push_back(project_point(px, py, pz));
   endtask

   task automatic write_entry(int idx, logic signed [WORD_W-1:0] val);
      send_word(OP_WRITE, idx[3:0], val, $urandom, $urandom, $urandom);
   endtask

   task automatic send_point(logic signed [WORD_W-1:0] px, logic signed [WORD_W-1:0] py,
                             logic signed [WORD_W-1:0] pz);
      send_word(OP_POINT, 4'($urandom), $urandom, px, py, pz);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_projections.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] small_fixed();
      return $signed(WORD_W'($urandom_range(0, 4 << FRAC))) - (2 << FRAC);
   endfunction

   // zero matrix gives w = 0; identity gives w = 1
   task automatic test_directed();
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      for (int i = 0; i < 16; i++)
         write_entry(i, (i % 5 == 0) ? (1 << FRAC) : 0);
      send_point(1 << FRAC, -(1 << FRAC), 0);
      send_point((1 << FRAC) + 1, 0, 0);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      // tiny w: bias 1 lsb saturates the reciprocal
      write_entry(15, 1);
      send_point(0, 0, 0);
      write_entry(15, -1);
      send_point(0, 0, 0);
      // huge w
      write_entry(15, 32'sh7FFF_FFFF);
      write_entry(11, 32'sh7FFF_FFFF);
      send_point(32'sh7FFF_FFFF, 5, -7);
      write_entry(15, 32'sh8000_0000);
      write_entry(11, 32'sh8000_0000);
      send_point(3, 4, 32'sh7FFF_FFFF);
      write_entry(15, 2 << FRAC);
      write_entry(11, 0);
      send_point(2 << FRAC, -(2 << FRAC), 1 << FRAC);
      send_point((2 << FRAC) + 1, 0, 0);
      drain_results();
   endtask

   task automatic test_random_projection(int count);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: write_entry($urandom_range(0, 15), $urandom);
            1, 2: write_entry($urandom_range(0, 15), small_fixed());
            3: send_point($urandom, $urandom, $urandom);
            default: send_point(small_fixed(), small_fixed(), small_fixed());
         endcase
         if (n == count / 2)
            drain_results();
      end
   endtask

   initial begin
      error_count = 0;
      burst_left  = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_WRITE;
      req_entry_index = '0;
      req_entry_value = '0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      for (int i = 0; i < 16; i++) matrix_copy[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_projection(1750);
      drain_results();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("point_project_clip_test_unit_tb: done, clean");
      else
         $display("point_project_clip_test_unit_tb: done, errors");
      $finish;
   end

endmodule
